### design/xkbd_pkg.sv
// shared types, register codes and keystream functions for the keyed byte decoder
package xkbd_pkg;

    localparam logic [2:0] CFG_KEY_WORD_ZERO  = 3'd0;
    localparam logic [2:0] CFG_KEY_WORD_ONE   = 3'd1;
    localparam logic [2:0] CFG_KEY_WORD_TWO   = 3'd2;
    localparam logic [2:0] CFG_KEY_WORD_THREE = 3'd3;
    localparam logic [2:0] CFG_KEY_LENGTH     = 3'd4;
    localparam logic [2:0] CFG_WORD_MODE      = 3'd5;

    localparam int KEY_REG_BYTES   = 32;
    localparam int MIN_KEY_BYTES   = 8;
    localparam int KEY_LENGTH_RST  = 16;
    localparam int DIV_STEPS       = 64;
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

    localparam int WIDE_SHIFT_A    = 13;
    localparam int WIDE_SHIFT_B    = 7;
    localparam int WIDE_SHIFT_C    = 17;
    localparam int NARROW_SHIFT_A  = 13;
    localparam int NARROW_SHIFT_B  = 17;
    localparam int NARROW_SHIFT_C  = 5;
    localparam int BYTE_BITS       = 8;

    typedef struct packed {
        logic step_now;
        logic load;
        logic div_step;
        logic step_held;
    } xkbd_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } xkbd_status_t;

    function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] s);
        logic [15:0] t;
        t = {v, v} << s;
        return t[15:8];
    endfunction

    function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] s);
        logic [15:0] t;
        t = {v, v} >> s;
        return t[7:0];
    endfunction

    function automatic logic [63:0] advance(input logic [63:0] x, input logic narrow);
        logic [31:0] y;
        logic [63:0] w;
        y = x[31:0];
        y = y ^ (y << NARROW_SHIFT_A);
        y = y ^ (y >> NARROW_SHIFT_B);
        y = y ^ (y << NARROW_SHIFT_C);
        w = x;
        w = w ^ (w << WIDE_SHIFT_A);
        w = w ^ (w >> WIDE_SHIFT_B);
        w = w ^ (w << WIDE_SHIFT_C);
        return narrow ? {32'b0, y} : w;
    endfunction

endpackage

### design/xkbd_ctrl.sv
// sequencing controller for the keyed byte decoder
module xkbd_ctrl
    import xkbd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         start_of_message,
    input  xkbd_status_t status,
    output logic         in_stall,
    output xkbd_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_stall = !((state_reg == ST_IDLE) && status.out_free);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (start_of_message)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        cmd.step_now = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.step_held = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/xkbd_datapath.sv
// key registers, keystream state, start index divider and byte transform
module xkbd_datapath
    import xkbd_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic [7:0]   cipher_byte,
    input  xkbd_cmd_t    cmd,
    input  logic         out_stall,
    output xkbd_status_t status,
    output logic         out_valid,
    output logic [7:0]   plain_byte
);

    localparam int PW = $clog2(MAX_KEY_BYTES);
    localparam int LW = $clog2(MAX_KEY_BYTES + 1);

    logic [63:0]          key0_reg, key1_reg, key2_reg, key3_reg;
    logic [5:0]           key_len_reg;
    logic                 mode_reg;
    logic [63:0]          sw_reg, sw_next;
    logic [63:0]          cnt_reg, cnt_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [7:0]           held_reg;
    logic [63:0]          dividend_reg;
    logic [6:0]           rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;

    logic [LW-1:0]        eff_len;
    logic [255:0]         key_bits;
    logic [63:0]          load_sw, load_cnt;
    logic [7:0]           trial;
    logic [6:0]           rem_next;
    logic                 do_step;
    logic [PW-1:0]        pos_use;
    logic [6:0]           pos_ext;
    logic [7:0]           byte_use;
    logic [7:0]           key_byte;
    logic [7:0]           b_rot, b_sub, b_key, b_out;
    logic [PW:0]          pos_inc;
    logic [PW-1:0]        pos_wrap;
    logic                 out_taken;

    always_comb
    begin
        if (key_len_reg < 6'(MIN_KEY_BYTES))
        begin
            eff_len = LW'(MIN_KEY_BYTES);
        end
        else if (7'(key_len_reg) > 7'(MAX_KEY_BYTES))
        begin
            eff_len = LW'(MAX_KEY_BYTES);
        end
        else
        begin
            eff_len = LW'(key_len_reg);
        end
    end

    assign key_bits = {key3_reg, key2_reg, key1_reg, key0_reg};
    assign load_sw  = mode_reg ? {32'b0, key0_reg[31:0]}  : key0_reg;
    assign load_cnt = mode_reg ? {32'b0, key0_reg[63:32]} : key1_reg;

    // restoring remainder, one dividend bit per cycle
    assign trial    = {rem_reg, dividend_reg[63]};
    assign rem_next = (trial >= 8'(eff_len)) ? 7'(trial - 8'(eff_len)) : trial[6:0];

    assign do_step  = cmd.step_now || cmd.step_held;
    assign pos_use  = cmd.step_held ? PW'(rem_reg) : pos_reg;
    assign byte_use = cmd.step_held ? held_reg : cipher_byte;
    assign pos_ext  = 7'(pos_use);

    always_comb
    begin
        if (pos_ext < 7'(KEY_REG_BYTES))
        begin
            key_byte = key_bits[pos_ext[4:0] * BYTE_BITS +: BYTE_BITS];
        end
        else
        begin
            key_byte = 8'd0;
        end
    end

    assign b_rot = rotl8(byte_use, sw_reg[2:0]);
    assign b_sub = b_rot - (cnt_reg[7:0] ^ sw_reg[7:0]);
    assign b_key = b_sub ^ key_byte;
    assign b_out = rotr8(b_key, sw_reg[2:0]) ^ sw_reg[7:0];

    assign pos_inc  = {1'b0, pos_use} + (PW + 1)'(1);
    assign pos_wrap = (8'(pos_inc) >= 8'(eff_len)) ? '0 : pos_inc[PW-1:0];

    always_comb
    begin
        sw_next  = sw_reg;
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        if (cmd.load)
        begin
            sw_next  = load_sw;
            cnt_next = load_cnt;
        end
        else if (do_step)
        begin
            sw_next  = advance(sw_reg, mode_reg);
            cnt_next = mode_reg ? {32'b0, cnt_reg[31:0] + 32'd1} : cnt_reg + 64'd1;
            pos_next = pos_wrap;
        end
    end

    assign out_taken = out_valid_reg && !out_stall;

    assign status.div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign plain_byte = out_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg      <= '0;
            key1_reg      <= '0;
            key2_reg      <= '0;
            key3_reg      <= '0;
            key_len_reg   <= 6'(KEY_LENGTH_RST);
            mode_reg      <= 1'b0;
            sw_reg        <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY_WORD_ZERO:  key0_reg    <= cfg_data;
                    CFG_KEY_WORD_ONE:   key1_reg    <= cfg_data;
                    CFG_KEY_WORD_TWO:   key2_reg    <= cfg_data;
                    CFG_KEY_WORD_THREE: key3_reg    <= cfg_data;
                    CFG_KEY_LENGTH:     key_len_reg <= cfg_data[5:0];
                    CFG_WORD_MODE:      mode_reg    <= cfg_data[0];
                    default:            ;
                endcase
            end
            sw_reg  <= sw_next;
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
            if (cmd.load)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            if (do_step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            held_reg     <= cipher_byte;
            dividend_reg <= load_sw;
            rem_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            dividend_reg <= {dividend_reg[62:0], 1'b0};
            rem_reg      <= rem_next;
        end
        if (do_step)
        begin
            out_byte_reg <= b_out;
        end
    end

endmodule

### design/xorshift_keyed_byte_decoder_top.sv
// top level of the xorshift keyed byte decoder
// Decodes one byte per item with a keystream drawn from a key of up to 32 bytes. A byte
// without the start flag is decoded on acceptance, and a new item is taken every cycle while the
// output side keeps up. A byte with the start flag reloads state and counter from the key
// and finds the start key index as the state word modulo the key length in a restoring
// remainder unit that handles one dividend bit per cycle; that item is loaded, then takes
// 64 remainder steps, then gives its result once the output is free. Every item gives
// exactly one result, held in an output register until taken. Key registers are written
// through the configuration channel, which is always ready; indexes 6 and 7 are ignored.
module xorshift_keyed_byte_decoder_top
    import xkbd_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  cipher_byte,
    input  logic        start_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  plain_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    xkbd_cmd_t    cmd;
    xkbd_status_t status;

    assign cfg_ready = 1'b1;

    xkbd_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .start_of_message (start_of_message),
        .status           (status),
        .in_stall         (in_stall),
        .cmd              (cmd)
    );

    xkbd_datapath #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cipher_byte (cipher_byte),
        .cmd         (cmd),
        .out_stall   (out_stall),
        .status      (status),
        .out_valid   (out_valid),
        .plain_byte  (plain_byte)
    );

endmodule

### design/xkbd_checker.sv
// port level checks for the keyed byte decoder and their binding
module xkbd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       start_of_message,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] plain_byte
);

    // plain item yields a result on the next cycle
    a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !start_of_message |=> out_valid)
        else $error("plain item gave no result");

    // start item holds the input side while the index is found
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && start_of_message |=> in_stall)
        else $error("input taken during start index search");

    // no new item while a stalled result waits
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output blocked");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(plain_byte))
        else $error("stalled result changed");

endmodule

bind xorshift_keyed_byte_decoder_top xkbd_checker u_xkbd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .start_of_message (start_of_message),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .plain_byte       (plain_byte)
);
